// ----- hw/rtl/wpf_pkg.sv -----
package wpf_pkg;

	// Operand width of the serial multiply lanes and of the square root.
	localparam int unsigned OPW = 34;
	// Product width of one lane, which also holds the dividend and quotient.
	localparam int unsigned PRW = 2 * OPW;
	// Width of the sum of squares.
	localparam int unsigned SSW = 66;

	localparam logic [6:0] MUL_LAST  = 7'(OPW - 1);
	localparam logic [6:0] SQRT_LAST = 7'(SSW / 2 - 1);
	localparam logic [6:0] DIV_LAST  = 7'(PRW - 1);

	typedef enum logic [1:0] {
		REQ_SET_POS  = 2'd0,
		REQ_NEW_PATH = 2'd1,
		REQ_APPEND   = 2'd2,
		REQ_TICK     = 2'd3
	} req_t;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_RD     = 13'b0000000000010,
		ST_LOAD   = 13'b0000000000100,
		ST_MSTEP  = 13'b0000000001000,
		ST_SQLD   = 13'b0000000010000,
		ST_MSQ    = 13'b0000000100000,
		ST_RTLD   = 13'b0000001000000,
		ST_SQRT   = 13'b0000010000000,
		ST_DECIDE = 13'b0000100000000,
		ST_MMV    = 13'b0001000000000,
		ST_DIV    = 13'b0010000000000,
		ST_APPLY  = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

endpackage

// ----- hw/rtl/waypoint_path_follower.sv -----
// Waypoint path follower: moves a point along a stored list of waypoints at the speed held
// in the configuration register, all values in Q16.16 fixed point.
// The input stream carries one item per request; tuser holds the request kind (set position,
// start a new path, append a waypoint, tick) and tdata its coordinates, node id and elapsed
// time. Every input item yields exactly one output item with the position, the index of the
// next waypoint, and the flags for a reached waypoint, the end of the path and a dropped append.
// The speed is written on the cfg channel, which is always ready; write it only while idle.
// A non-tick item, or a tick with no waypoint left, goes straight to the output stage. A tick
// reads its waypoint, multiplies speed by elapsed time, squares the axis distances and takes
// the square root; a tick that snaps onto its waypoint stops there, while a partial move goes
// on to scale each axis by the step and divide by the root. The datapath is bit-serial: two
// shift-add multiply lanes retire one multiplier bit per cycle, the square root one root bit
// per cycle and the divider one quotient bit per cycle. One item is worked on at a time.
// The result sits in an output register, so the next item is accepted while it waits; a
// stalled receiver only holds the block once the following result is ready.
// Reset clears position, path length, path index, speed and the output valid; the waypoint
// memory is not cleared, since only entries below the path length are ever read.
module waypoint_path_follower #(
	parameter int MAX_WAYPOINTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // coord_x[31:0], coord_y[63:32], node_id[79:64],
	                                // elapsed[111:80]
	input  logic [1:0]   s_tuser,   // req_type[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,   // pos_x[31:0], pos_y[63:32], waypoint_index[68:64],
	                                // end_node[84:69], zero fill[87:85]
	output logic [2:0]   m_tuser,   // reached_waypoint[0], end_reached[1], load_overflow[2]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);
	import wpf_pkg::*;

	localparam int IW = $clog2(MAX_WAYPOINTS + 1);
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam logic [IW-1:0] MAX_W = IW'(MAX_WAYPOINTS);

	state_t state_q;

	logic [31:0]   speed_q;
	logic [31:0]   cur_x_q, cur_y_q;
	logic [IW-1:0] path_len_q, path_idx_q;

	// Waypoint and node memories: written at one address, read registered.
	logic [63:0] wp_mem [MAX_WAYPOINTS];
	logic [15:0] nd_mem [MAX_WAYPOINTS];
	logic [63:0] wp_rd_q;
	logic [15:0] nd_rd_q;

	// Latched tick operands.
	logic [31:0] elapsed_q;
	logic [31:0] tx_q, ty_q;
	logic [31:0] ax_q, ay_q;
	logic        negx_q, negy_q;
	logic [47:0] step_q;

	// Two serial lanes; the product register also holds dividend and quotient.
	logic [PRW-1:0] p_q     [2];
	logic [OPW-1:0] mcand_q [2];
	logic [OPW-1:0] r_q     [2];

	// Square root: radicand shift register, partial remainder and root.
	logic [SSW-1:0] rad_q;
	logic [OPW-1:0] sr_q;
	logic [OPW-1:0] root_q;

	logic [6:0] cnt_q;

	// Result fields waiting for the output register.
	logic        reached_q, ended_q, ovf_q;
	logic [15:0] end_node_q;

	logic [PRW-1:0] p_mul [2];
	logic [PRW-1:0] p_div [2];
	logic [OPW-1:0] r_div [2];

	logic [35:0]    sq_t, sq_trial;
	logic           sq_ge;
	logic [SSW-1:0] sum_sq;

	logic [32:0] dx, dy;
	logic [32:0] adx, ady;

	logic        snap;
	logic [47:0] root_ext;
	logic [31:0] mx, my;

	logic [IW-1:0] idx_next;
	logic [IW-1:0] last_idx;
	logic [IW+4:0] widx_ext;

	logic        in_acc;
	logic        out_free;
	logic [1:0]  req;
	logic [31:0] in_x, in_y, in_el;
	logic [15:0] in_node;

	assign in_x    = s_tdata[31:0];
	assign in_y    = s_tdata[63:32];
	assign in_node = s_tdata[79:64];
	assign in_el   = s_tdata[111:80];
	assign req     = s_tuser;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;

	assign idx_next = path_idx_q + IW'(1);
	assign last_idx = path_len_q - IW'(1);
	assign widx_ext = {5'b00000, path_idx_q};

	// One shift-add step per lane: add the multiplicand when the low bit is set, shift right.
	// One restoring division step per lane: shift in the next dividend bit, try to subtract.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [OPW:0] psum;
			logic [OPW:0] dt;
			psum = {1'b0, p_q[l][PRW-1:OPW]} + (p_q[l][0] ? {1'b0, mcand_q[l]} : '0);
			p_mul[l] = {psum, p_q[l][OPW-1:1]};
			dt = {r_q[l], p_q[l][PRW-1]};
			if (dt >= {1'b0, root_q}) begin
				r_div[l] = OPW'(dt - {1'b0, root_q});
				p_div[l] = {p_q[l][PRW-2:0], 1'b1};
			end else begin
				r_div[l] = dt[OPW-1:0];
				p_div[l] = {p_q[l][PRW-2:0], 1'b0};
			end
		end
	end

	// One root bit per cycle.
	assign sq_t     = {sr_q, rad_q[SSW-1:SSW-2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = (sq_t >= sq_trial);

	assign sum_sq = p_q[0][SSW-1:0] + p_q[1][SSW-1:0];

	assign dx  = {wp_rd_q[63], wp_rd_q[63:32]} - {cur_x_q[31], cur_x_q};
	assign dy  = {wp_rd_q[31], wp_rd_q[31:0]} - {cur_y_q[31], cur_y_q};
	assign adx = dx[32] ? (33'd0 - dx) : dx;
	assign ady = dy[32] ? (33'd0 - dy) : dy;

	// step^2 >= s exactly when step exceeds floor(sqrt(s)), or equals it with no remainder.
	assign root_ext = {14'd0, root_q};
	assign snap     = (step_q > root_ext) || ((step_q == root_ext) && (sr_q == '0));

	assign mx = p_q[0][31:0];
	assign my = p_q[1][31:0];

	always_ff @(posedge clk) begin
		wp_rd_q <= wp_mem[path_idx_q[AW-1:0]];
		nd_rd_q <= nd_mem[last_idx[AW-1:0]];
		if (in_acc && (req == REQ_NEW_PATH)) begin
			wp_mem[0] <= {in_x, in_y};
			nd_mem[0] <= in_node;
		end else if (in_acc && (req == REQ_APPEND) && (path_len_q < MAX_W)) begin
			wp_mem[path_len_q[AW-1:0]] <= {in_x, in_y};
			nd_mem[path_len_q[AW-1:0]] <= in_node;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			speed_q    <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			path_len_q <= '0;
			path_idx_q <= '0;
			m_tvalid   <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				speed_q <= cfg_data;
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						reached_q  <= 1'b0;
						ended_q    <= 1'b0;
						ovf_q      <= 1'b0;
						end_node_q <= '0;
						elapsed_q  <= in_el;
						state_q    <= ST_FIN;
						case (req)
							REQ_SET_POS: begin
								cur_x_q <= in_x;
								cur_y_q <= in_y;
							end
							REQ_NEW_PATH: begin
								path_len_q <= IW'(1);
								path_idx_q <= '0;
							end
							REQ_APPEND: begin
								if (path_len_q < MAX_W) begin
									path_len_q <= path_len_q + IW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							default: begin
								if (path_idx_q < path_len_q) begin
									state_q <= ST_RD;
								end
							end
						endcase
					end
				end
				ST_RD: begin
					// The memory read at the path index lands in this cycle.
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					tx_q       <= wp_rd_q[63:32];
					ty_q       <= wp_rd_q[31:0];
					negx_q     <= dx[32];
					negy_q     <= dy[32];
					ax_q       <= adx[31:0];
					ay_q       <= ady[31:0];
					mcand_q[0] <= OPW'(speed_q);
					p_q[0]     <= {{OPW{1'b0}}, OPW'(elapsed_q)};
					mcand_q[1] <= '0;
					p_q[1]     <= '0;
					r_q[0]     <= '0;
					r_q[1]     <= '0;
					cnt_q      <= MUL_LAST;
					state_q    <= ST_MSTEP;
				end
				ST_MSTEP: begin
					p_q[0] <= p_mul[0];
					p_q[1] <= p_mul[1];
					if (cnt_q == '0) begin
						state_q <= ST_SQLD;
					end
				end
				ST_SQLD: begin
					step_q     <= p_q[0][63:16];
					mcand_q[0] <= OPW'(ax_q);
					p_q[0]     <= {{OPW{1'b0}}, OPW'(ax_q)};
					mcand_q[1] <= OPW'(ay_q);
					p_q[1]     <= {{OPW{1'b0}}, OPW'(ay_q)};
					cnt_q      <= MUL_LAST;
					state_q    <= ST_MSQ;
				end
				ST_MSQ: begin
					p_q[0] <= p_mul[0];
					p_q[1] <= p_mul[1];
					if (cnt_q == '0) begin
						state_q <= ST_RTLD;
					end
				end
				ST_RTLD: begin
					rad_q   <= sum_sq;
					sr_q    <= '0;
					root_q  <= '0;
					cnt_q   <= SQRT_LAST;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					rad_q <= {rad_q[SSW-3:0], 2'b00};
					if (sq_ge) begin
						sr_q   <= OPW'(sq_t - sq_trial);
						root_q <= {root_q[OPW-2:0], 1'b1};
					end else begin
						sr_q   <= sq_t[OPW-1:0];
						root_q <= {root_q[OPW-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (snap) begin
						cur_x_q    <= tx_q;
						cur_y_q    <= ty_q;
						path_idx_q <= idx_next;
						reached_q  <= 1'b1;
						if (idx_next >= path_len_q) begin
							ended_q    <= 1'b1;
							end_node_q <= nd_rd_q;
						end
						state_q <= ST_FIN;
					end else begin
						// Here the step is below the distance, so it fits a lane operand.
						mcand_q[0] <= step_q[OPW-1:0];
						p_q[0]     <= {{OPW{1'b0}}, OPW'(ax_q)};
						mcand_q[1] <= step_q[OPW-1:0];
						p_q[1]     <= {{OPW{1'b0}}, OPW'(ay_q)};
						cnt_q      <= MUL_LAST;
						state_q    <= ST_MMV;
					end
				end
				ST_MMV: begin
					p_q[0] <= p_mul[0];
					p_q[1] <= p_mul[1];
					if (cnt_q == '0) begin
						cnt_q   <= DIV_LAST;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					p_q[0] <= p_div[0];
					p_q[1] <= p_div[1];
					r_q[0] <= r_div[0];
					r_q[1] <= r_div[1];
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					cur_x_q <= negx_q ? (cur_x_q - mx) : (cur_x_q + mx);
					cur_y_q <= negy_q ? (cur_y_q - my) : (cur_y_q + my);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tdata  <= {3'b000, end_node_q, widx_ext[4:0], cur_y_q, cur_x_q};
						m_tuser  <= {ovf_q, ended_q, reached_q};
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- verif/waypoint_path_follower_chk.sv -----
`timescale 1ns / 100ps

module waypoint_path_follower_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [87:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending_count,
	output int           result_count,
	output int           snap_count,
	output int           end_count,
	output int           drop_count
);
	import wpf_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [4:0]  waypoint_index;
		logic        reached;
		logic        ended;
		logic [15:0] end_node;
		logic        overflow;
	} motion_t;

	// Shadow of the follower's state.
	logic [31:0]        speed;
	logic signed [63:0] px, py;
	logic [31:0]        wp_x [DEPTH];
	logic [31:0]        wp_y [DEPTH];
	logic [15:0]        wp_node [DEPTH];
	int unsigned        path_len, path_idx;
	motion_t            motion_q [$];

	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	// Advances the shadow state by one item and returns the motion it yields.
	function automatic motion_t advance(logic [1:0] kind, logic [111:0] d);
		motion_t m;
		logic signed [63:0] x, y, tx, ty, dx, dy;
		logic [127:0] ax, ay, dist2, step;
		logic [63:0] len;
		x = 64'(signed'(d[31:0]));
		y = 64'(signed'(d[63:32]));
		m = '0;
		case (req_t'(kind))
			REQ_SET_POS: begin
				px = x;
				py = y;
			end
			REQ_NEW_PATH: begin
				wp_x[0] = d[31:0];
				wp_y[0] = d[63:32];
				wp_node[0] = d[79:64];
				path_len = 1;
				path_idx = 0;
			end
			REQ_APPEND: begin
				if (path_len < DEPTH) begin
					wp_x[path_len] = d[31:0];
					wp_y[path_len] = d[63:32];
					wp_node[path_len] = d[79:64];
					path_len++;
				end else begin
					m.overflow = 1'b1;
				end
			end
			default: begin
				if (path_idx < path_len) begin
					tx = 64'(signed'(wp_x[path_idx]));
					ty = 64'(signed'(wp_y[path_idx]));
					dx = tx - px;
					dy = ty - py;
					ax = 128'(dx < 0 ? -dx : dx);
					ay = 128'(dy < 0 ? -dy : dy);
					dist2 = ax * ax + ay * ay;
					step = ({96'd0, speed} * {96'd0, d[111:80]}) >> 16;
					if (step * step >= dist2) begin
						px = tx;
						py = ty;
						path_idx++;
						m.reached = 1'b1;
						if (path_idx >= path_len) begin
							m.ended = 1'b1;
							m.end_node = wp_node[path_len - 1];
						end
					end else begin
						// Rounded toward zero on each axis, so the move stops short.
						len = isqrt(dist2);
						ax = (step * ax) / len;
						ay = (step * ay) / len;
						px = dx < 0 ? px - 64'(ax) : px + 64'(ax);
						py = dy < 0 ? py - 64'(ay) : py + 64'(ay);
					end
				end
			end
		endcase
		m.pos_x = px[31:0];
		m.pos_y = py[31:0];
		m.waypoint_index = path_idx[4:0];
		return m;
	endfunction

	assign pending_count = motion_q.size();

	always @(posedge clk or negedge arst_n) begin
		motion_t e;
		motion_t got;
		if (!arst_n) begin
			speed <= '0;
			px = 0;
			py = 0;
			path_len = 0;
			path_idx = 0;
			motion_q.delete();
			fail_count <= 0;
			result_count <= 0;
			snap_count <= 0;
			end_count <= 0;
			drop_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				speed <= cfg_data;
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[68:64], m_tuser[0],
					m_tuser[1], m_tdata[84:69], m_tuser[2]};
				result_count <= result_count + 1;
				snap_count <= snap_count + got.reached;
				end_count <= end_count + got.ended;
				drop_count <= drop_count + got.overflow;
				if (motion_q.size() == 0) begin
					$error("unexpected output item %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = motion_q.pop_front();
					if (got != e || m_tdata[87:85] != 3'd0) begin
						fail_count <= fail_count + 1;
						if (got.pos_x != e.pos_x)
							$error("pos_x exp %h got %h", e.pos_x, got.pos_x);
						if (got.pos_y != e.pos_y)
							$error("pos_y exp %h got %h", e.pos_y, got.pos_y);
						if (got.waypoint_index != e.waypoint_index)
							$error("waypoint_index exp %0d got %0d", e.waypoint_index,
								got.waypoint_index);
						if (got.reached != e.reached)
							$error("reached_waypoint exp %b got %b", e.reached, got.reached);
						if (got.ended != e.ended)
							$error("end_reached exp %b got %b", e.ended, got.ended);
						if (got.end_node != e.end_node)
							$error("end_node exp %h got %h", e.end_node, got.end_node);
						if (got.overflow != e.overflow)
							$error("load_overflow exp %b got %b", e.overflow, got.overflow);
						if (m_tdata[87:85] != 3'd0)
							$error("zero fill exp 0 got %b", m_tdata[87:85]);
					end
				end
			end
			if (s_tvalid && s_tready)
				motion_q.push_back(advance(s_tuser, s_tdata));
		end
	end

endmodule

// ----- verif/waypoint_path_follower_tb.sv -----
`timescale 1ns / 100ps

module waypoint_path_follower_tb;
	import wpf_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;   // coord_x[31:0], coord_y[63:32], node_id[79:64],
	                              // elapsed[111:80]
	logic [1:0]   s_tuser = '0;   // req_type[1:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;        // pos_x[31:0], pos_y[63:32], waypoint_index[68:64],
	                              // end_node[84:69], zero fill[87:85]
	logic [2:0]   m_tuser;        // reached_waypoint[0], end_reached[1], load_overflow[2]
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data = '0;

	int fail_count, pending_count, result_count, snap_count, end_count, drop_count;
	int items_sent;
	bit hold_off;
	bit hold_done;
	bit drain_fast;

	always #2 clk = ~clk;

	waypoint_path_follower dut (.*);

	waypoint_path_follower_chk chk (.*);

	// The receiver stalls on its own pattern; during a hold-off it refuses everything, so
	// the follower's output register fills and the input stops being accepted.
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else if (drain_fast)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 9) < 6);
	end

	// Offers one item and waits for the handshake. Gaps come in bursts: inside a burst
	// valid stays high from one item to the next.
	task automatic offer(input req_t kind, input logic [31:0] x, input logic [31:0] y,
			input logic [15:0] node, input logic [31:0] dt);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {dt, node, y, x};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Waits until every expected result has come back, then lets a tick finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_speed(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord(input int span);
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'd0;
			default: return $urandom_range(0, 32'h0003ffff);
		endcase
	endfunction

	// A well-formed route: a new path, some appends (sometimes past capacity), ticks.
	task automatic route(input int span);
		int legs;
		legs = $urandom_range(0, 18);
		offer(REQ_NEW_PATH, rand_coord(span), rand_coord(span), 16'($urandom()), $urandom());
		idle_gap();
		for (int i = 0; i < legs; i++) begin
			offer(REQ_APPEND, rand_coord(span), rand_coord(span), 16'($urandom()),
				$urandom());
			idle_gap();
		end
		repeat ($urandom_range(2, 12)) begin
			offer(REQ_TICK, $urandom(), $urandom(), 16'($urandom()), rand_dt());
			idle_gap();
		end
	endtask

	initial begin
		logic [31:0] speeds [4];
		speeds = '{32'h00010000, 32'hffffffff, 32'h00003000, 32'h0};
		items_sent = 0;
		hold_off = 1'b0;
		hold_done = 1'b0;
		drain_fast = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tick with no path, zero speed snap onto the current point, extremes.
		offer(REQ_TICK, '1, '1, '1, '1);
		offer(REQ_NEW_PATH, 32'h0, 32'h0, 16'hffff, 32'h0);
		offer(REQ_TICK, 32'h0, 32'h0, 16'h0, 32'h0);
		offer(REQ_TICK, 32'h0, 32'h0, 16'h0, 32'hffffffff);
		drain();
		write_speed(32'h00010000);
		offer(REQ_SET_POS, 32'h80000000, 32'h7fffffff, 16'h0, 32'h0);
		offer(REQ_NEW_PATH, 32'h7fffffff, 32'h80000000, 16'h1234, 32'h0);
		offer(REQ_TICK, 32'h0, 32'h0, 16'h0, 32'h00010000);
		offer(REQ_TICK, 32'h0, 32'h0, 16'h0, 32'hffffffff);
		for (int i = 0; i < 16; i++)
			offer(REQ_APPEND, i << 18, -(i << 17), 16'(i), 32'h0);
		offer(REQ_TICK, 32'h0, 32'h0, 16'h0, 32'h00008000);
		drain();

		// Random phases with a different speed each; the extremes are among them.
		for (int ph = 0; ph < 4; ph++) begin
			write_speed(speeds[ph]);
			while (items_sent < 260 * (ph + 1)) begin
				if ($urandom_range(0, 7) == 0) begin
					offer(req_t'($urandom_range(0, 3)), $urandom(), $urandom(),
						16'($urandom()), $urandom());
				end else begin
					route(ph == 1 ? 32'h7fff_ffff : 32'h0020_0000);
				end
				// Once, hold the receiver off while items keep coming.
				if (ph == 2 && !hold_done && items_sent > 600) begin
					hold_done = 1'b1;
					hold_off = 1'b1;
					fork
						begin
							repeat (600) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
			end
			drain_fast = (ph == 2);
			drain();
			drain_fast = 1'b0;
		end

		$display("Sent %0d items, checked %0d results: %0d snaps, %0d path ends, %0d drops.",
			items_sent, result_count, snap_count, end_count, drop_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
